// ===== rtl/text_line_justifier_unit_macros.svh =====
// Assertion macros for the text line justifier RTL.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef TEXT_LINE_JUSTIFIER_UNIT_MACROS_SVH
`define TEXT_LINE_JUSTIFIER_UNIT_MACROS_SVH

// Check that cond implies prop in the same cycle.
`define TLJ_ASSERT_IMP(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error(msg);

// Check that cond implies prop in the following cycle.
`define TLJ_ASSERT_NXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);

`endif

// ===== rtl/tlj_pkg.sv =====
// Package for the text line justifier: payload structs and width constants.
// No dependencies; used by text_line_justifier_unit.
package tlj_pkg;

  localparam int WIDTH_LIMIT = 127;

  typedef struct packed {
    logic [6:0] word_len;
    logic       last_word;
  } in_beat_t;

  typedef struct packed {
    logic [6:0] word_count;
    logic [6:0] gap_spaces;
    logic [5:0] extra_gaps;
    logic [6:0] tail_pad;
    logic       final_line;
    logic       run_end;
    logic       word_too_long;
  } out_beat_t;

endpackage

// ===== rtl/text_line_justifier_unit.sv =====
// Greedy full text justifier: packs word lengths into lines, emits line descriptors.
// Depends on tlj_pkg and text_line_justifier_unit_macros.svh.
//
//   channel | direction | handshake        | payload
//   in_     | input     | in_valid/in_stall | tlj_pkg::in_beat_t
//   out_    | output    | out_valid/out_stall | tlj_pkg::out_beat_t
//   cfg_    | input     | cfg_we           | max_width (7 bits)
//
// A word that closes no line is taken in ST_IDLE; a closed single-word line passes
// through ST_CLOSE and a final line through ST_LAST; a closed multi-word line first runs
// the restoring divider in ST_DIV, then ST_CLOSE loads the output register.
// Synchronous active-low reset clears the open line and sets max_width to 16.
// Output stalls hold the result register; the input stalls until every pending result is loaded.
`include "text_line_justifier_unit_macros.svh"

module text_line_justifier_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  tlj_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output tlj_pkg::out_beat_t out_data,
  input  logic               cfg_we,
  input  logic [6:0]         cfg_wdata
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_DIV   = 4'b0010,
    ST_CLOSE = 4'b0100,
    ST_LAST  = 4'b1000
  } state_t;

  state_t             state_r, state_nxt;
  logic [6:0]         max_width_r;
  logic [6:0]         line_chars_r, line_chars_nxt;
  logic [6:0]         line_words_r, line_words_nxt;
  logic               line_clamp_r, line_clamp_nxt;
  logic [6:0]         cl_words_r, cl_words_nxt;
  logic               cl_clamp_r, cl_clamp_nxt;
  logic               cl_single_r, cl_single_nxt;
  logic [6:0]         quo_r, quo_nxt;
  logic [5:0]         rem_r, rem_nxt;
  logic [5:0]         dsr_r, dsr_nxt;
  logic [2:0]         cnt_r, cnt_nxt;
  logic [6:0]         ls_words_r, ls_words_nxt;
  logic [6:0]         ls_tail_r, ls_tail_nxt;
  logic               ls_clamp_r, ls_clamp_nxt;
  logic               ls_pend_r, ls_pend_nxt;
  logic               out_valid_r, out_valid_nxt;
  tlj_pkg::out_beat_t out_data_r, out_data_nxt;

  logic       accept;
  logic       out_free;
  logic [6:0] w_c;
  logic [6:0] len_c;
  logic [6:0] len_eff;
  logic       clamp_c;
  logic       close_c;
  logic [8:0] fit_sum;
  logic [6:0] freesp_c;
  logic [6:0] new_chars;
  logic [6:0] new_words;
  logic       new_clamp;
  logic [7:0] used_c;
  logic [6:0] trial;
  logic       ge;

  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    if (max_width_r == 7'd0) begin
      w_c = 7'd1;
    end else if ({5'd0, max_width_r} > 12'(tlj_pkg::WIDTH_LIMIT)) begin
      w_c = 7'(tlj_pkg::WIDTH_LIMIT);
    end else begin
      w_c = max_width_r;
    end
    len_c    = (in_data.word_len == 7'd0) ? 7'd1 : in_data.word_len;
    clamp_c  = len_c > w_c;
    len_eff  = clamp_c ? w_c : len_c;
    fit_sum  = {2'd0, line_chars_r} + {2'd0, len_eff} + {2'd0, line_words_r};
    close_c  = (line_words_r != 7'd0) && (fit_sum > {2'd0, w_c});
    freesp_c = (w_c > line_chars_r) ? (w_c - line_chars_r) : 7'd0;
    if (close_c) begin
      new_chars = len_eff;
      new_words = 7'd1;
      new_clamp = clamp_c;
    end else begin
      new_chars = line_chars_r + len_eff;
      new_words = line_words_r + 7'd1;
      new_clamp = line_clamp_r || clamp_c;
    end
    used_c = {1'b0, new_chars} + {1'b0, new_words} - 8'd1;
    trial  = {rem_r, quo_r[6]};
    ge     = trial >= {1'b0, dsr_r};
  end

  always_comb begin
    state_nxt      = state_r;
    line_chars_nxt = line_chars_r;
    line_words_nxt = line_words_r;
    line_clamp_nxt = line_clamp_r;
    cl_words_nxt   = cl_words_r;
    cl_clamp_nxt   = cl_clamp_r;
    cl_single_nxt  = cl_single_r;
    quo_nxt        = quo_r;
    rem_nxt        = rem_r;
    dsr_nxt        = dsr_r;
    cnt_nxt        = cnt_r;
    ls_words_nxt   = ls_words_r;
    ls_tail_nxt    = ls_tail_r;
    ls_clamp_nxt   = ls_clamp_r;
    ls_pend_nxt    = ls_pend_r;
    out_data_nxt   = out_data_r;
    out_valid_nxt  = out_valid_r && out_stall;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cl_words_nxt  = line_words_r;
          cl_clamp_nxt  = line_clamp_r;
          cl_single_nxt = (line_words_r == 7'd1);
          quo_nxt       = freesp_c;
          rem_nxt       = 6'd0;
          dsr_nxt       = 6'(line_words_r - 7'd1);
          cnt_nxt       = 3'd0;
          ls_words_nxt  = new_words;
          ls_clamp_nxt  = new_clamp;
          ls_tail_nxt   = ({1'b0, w_c} > used_c) ? (w_c - used_c[6:0]) : 7'd0;
          ls_pend_nxt   = in_data.last_word;
          if (in_data.last_word) begin
            line_chars_nxt = 7'd0;
            line_words_nxt = 7'd0;
            line_clamp_nxt = 1'b0;
          end else begin
            line_chars_nxt = new_chars;
            line_words_nxt = new_words;
            line_clamp_nxt = new_clamp;
          end
          priority if (close_c && line_words_r != 7'd1) begin
            state_nxt = ST_DIV;
          end else if (close_c) begin
            state_nxt = ST_CLOSE;
          end else if (in_data.last_word) begin
            state_nxt = ST_LAST;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_DIV: begin
        quo_nxt = {quo_r[5:0], ge};
        rem_nxt = ge ? 6'(trial - {1'b0, dsr_r}) : trial[5:0];
        cnt_nxt = cnt_r + 3'd1;
        if (cnt_r == 3'd6) begin
          state_nxt = ST_CLOSE;
        end
      end
      ST_CLOSE: begin
        if (out_free) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.word_count    = cl_words_r;
          out_data_nxt.gap_spaces    = cl_single_r ? 7'd0 : quo_r;
          out_data_nxt.extra_gaps    = cl_single_r ? 6'd0 : rem_r;
          out_data_nxt.tail_pad      = cl_single_r ? quo_r : 7'd0;
          out_data_nxt.final_line    = 1'b0;
          out_data_nxt.run_end       = !ls_pend_r;
          out_data_nxt.word_too_long = cl_clamp_r;
          state_nxt = ls_pend_r ? ST_LAST : ST_IDLE;
        end
      end
      ST_LAST: begin
        if (out_free) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.word_count    = ls_words_r;
          out_data_nxt.gap_spaces    = 7'd1;
          out_data_nxt.extra_gaps    = 6'd0;
          out_data_nxt.tail_pad      = ls_tail_r;
          out_data_nxt.final_line    = 1'b1;
          out_data_nxt.run_end       = 1'b1;
          out_data_nxt.word_too_long = ls_clamp_r;
          ls_pend_nxt                = 1'b0;
          state_nxt                  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      max_width_r  <= 7'd16;
      line_chars_r <= 7'd0;
      line_words_r <= 7'd0;
      line_clamp_r <= 1'b0;
      ls_pend_r    <= 1'b0;
      cnt_r        <= 3'd0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      line_chars_r <= line_chars_nxt;
      line_words_r <= line_words_nxt;
      line_clamp_r <= line_clamp_nxt;
      ls_pend_r    <= ls_pend_nxt;
      cnt_r        <= cnt_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_we) begin
        max_width_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    cl_words_r  <= cl_words_nxt;
    cl_clamp_r  <= cl_clamp_nxt;
    cl_single_r <= cl_single_nxt;
    quo_r       <= quo_nxt;
    rem_r       <= rem_nxt;
    dsr_r       <= dsr_nxt;
    ls_words_r  <= ls_words_nxt;
    ls_tail_r   <= ls_tail_nxt;
    ls_clamp_r  <= ls_clamp_nxt;
    out_data_r  <= out_data_nxt;
  end

  `TLJ_ASSERT_IMP(a_final_ends_run, out_valid_r && out_data_r.final_line,
                  out_data_r.run_end, "final line without run_end")
  `TLJ_ASSERT_IMP(a_gap_line_no_tail,
                  out_valid_r && !out_data_r.final_line && out_data_r.word_count > 7'd1,
                  out_data_r.tail_pad == 7'd0 &&
                  {1'b0, out_data_r.extra_gaps} < out_data_r.word_count - 7'd1,
                  "bad multi-word descriptor")
  `TLJ_ASSERT_NXT(a_div_exits_to_close, state_r == ST_DIV,
                  state_r == ST_DIV || state_r == ST_CLOSE, "divider left early")
  `TLJ_ASSERT_IMP(a_line_words_bound, 1'b1, line_words_r <= 7'd64,
                  "open line holds too many words")
  `TLJ_ASSERT_NXT(a_held_result, out_valid_r && out_stall,
                  out_valid_r && $stable(out_data_r), "stalled result changed")

endmodule

// ===== tb/sv/tb_text_line_justifier_unit.sv =====
// Testbench for text_line_justifier_unit: drives word-length beats and checks every
// line descriptor against an in-bench greedy justification predictor.
// Depends on tlj_pkg and the text_line_justifier_unit RTL.
module tb_text_line_justifier_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 16;
  localparam int PHASE_WORDS   = 400;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  tlj_pkg::in_beat_t  in_data   = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  tlj_pkg::out_beat_t out_data;
  logic               cfg_we    = 1'b0;
  logic [6:0]         cfg_wdata = '0;

  int line_width = 16;
  int open_chars = 0;
  int open_words = 0;
  bit open_clamped = 1'b0;
  tlj_pkg::out_beat_t expected_lines[$];

  int in_idle_pct   = 0;
  int out_stall_pct = 0;
  int hold_off      = 0;
  int errors        = 0;
  int quiet_cycles  = 0;
  int words_sent    = 0;
  int lines_checked = 0;
  int finals_seen   = 0;
  int width_writes  = 0;

  text_line_justifier_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #4 clk = ~clk;

  function automatic void justify_word(tlj_pkg::in_beat_t b);
    tlj_pkg::out_beat_t rec[2];
    int w;
    int len;
    int n;
    int free_sp;
    int used;
    bit clamp;
    w = line_width;
    if (w > tlj_pkg::WIDTH_LIMIT) w = tlj_pkg::WIDTH_LIMIT;
    if (w == 0) w = 1;
    len = b.word_len;
    if (len == 0) len = 1;
    clamp = 1'b0;
    if (len > w) begin
      len = w;
      clamp = 1'b1;
    end
    n = 0;
    if (open_words > 0 && open_chars + len + open_words > w) begin
      free_sp = (w > open_chars) ? w - open_chars : 0;
      rec[n] = '0;
      rec[n].word_count = 7'(open_words);
      rec[n].word_too_long = open_clamped;
      if (open_words == 1) begin
        rec[n].tail_pad = 7'(free_sp);
      end else begin
        rec[n].gap_spaces = 7'(free_sp / (open_words - 1));
        rec[n].extra_gaps = 6'(free_sp % (open_words - 1));
      end
      n++;
      open_chars = 0;
      open_words = 0;
      open_clamped = 1'b0;
    end
    open_chars += len;
    open_words += 1;
    if (clamp) open_clamped = 1'b1;
    if (b.last_word) begin
      used = open_chars + open_words - 1;
      rec[n] = '0;
      rec[n].word_count = 7'(open_words);
      rec[n].gap_spaces = 7'd1;
      rec[n].tail_pad = 7'((w > used) ? w - used : 0);
      rec[n].final_line = 1'b1;
      rec[n].word_too_long = open_clamped;
      n++;
      open_chars = 0;
      open_words = 0;
      open_clamped = 1'b0;
    end
    open_chars &= 127;
    open_words &= 127;
    for (int i = 0; i < n; i++) begin
      if (i == n - 1) rec[i].run_end = 1'b1;
      expected_lines = {expected_lines, rec[i]};
    end
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin : scoreboard
    tlj_pkg::out_beat_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        justify_word(in_data);
        words_sent++;
      end
      if (out_valid && !out_stall) begin
        if (expected_lines.size() == 0) begin
          errors++;
          $display("%0t ns: unexpected line beat, expected none, got %p", $time, out_data);
        end else begin
          want = expected_lines.pop_front();
          check_field("word_count", want.word_count, out_data.word_count);
          check_field("gap_spaces", want.gap_spaces, out_data.gap_spaces);
          check_field("extra_gaps", want.extra_gaps, out_data.extra_gaps);
          check_field("tail_pad", want.tail_pad, out_data.tail_pad);
          check_field("final_line", want.final_line, out_data.final_line);
          check_field("run_end", want.run_end, out_data.run_end);
          check_field("word_too_long", want.word_too_long, out_data.word_too_long);
          lines_checked++;
          if (want.final_line) finals_seen++;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (hold_off > 0) begin
      out_stall = 1'b1;
      hold_off--;
    end else begin
      out_stall = ($urandom_range(99) < out_stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t ns: no beat moved for %0d cycles, %0d lines still expected",
                 $time, quiet_cycles, expected_lines.size());
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  task automatic send_word(input int len, input bit last);
    @(negedge clk);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data.word_len = 7'(len);
    in_data.last_word = last;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic settle_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_lines.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_width(input int v);
    settle_idle();
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = 7'(v);
    @(negedge clk);
    cfg_we = 1'b0;
    line_width = v & 127;
    width_writes++;
  endtask

  function automatic int pick_width();
    case ($urandom_range(7))
      0: return 0;
      1: return 1;
      2: return 127;
      3: return 16;
      4: return $urandom_range(2, 12);
      5: return $urandom_range(30, 80);
      default: return $urandom_range(127);
    endcase
  endfunction

  function automatic int pick_len(input int w, input bit ones);
    int r;
    int top;
    r = $urandom_range(99);
    top = (w < 1) ? 1 : w;
    if (ones) return 1;
    if (r < 4) return 0;
    if (r < 10) return $urandom_range(127);
    if (r < 45) return $urandom_range(1, (top < 4) ? top : 4);
    return $urandom_range(1, top);
  endfunction

  task automatic send_text(input int nw, input bit ones, input bit flush);
    for (int i = 0; i < nw; i++)
      send_word(pick_len(line_width, ones), flush && (i == nw - 1));
  endtask

  task automatic test_directed();
    in_idle_pct = 0;
    out_stall_pct = 0;
    send_word(0, 1'b0);
    send_word(127, 1'b0);
    send_word(5, 1'b0);
    send_word(4, 1'b0);
    send_word(3, 1'b1);
    send_word(5, 1'b0);
    send_word(5, 1'b0);
    send_word(5, 1'b0);
    send_word(3, 1'b0);
    send_word(3, 1'b0);
    send_word(3, 1'b0);
    send_word(6, 1'b0);
    send_word(6, 1'b1);
    set_width(127);
    send_word(127, 1'b1);
    send_word(63, 1'b0);
    send_word(63, 1'b1);
    set_width(0);
    send_word(0, 1'b0);
    send_word(1, 1'b0);
    send_word(2, 1'b1);
    set_width(16);
    send_word(10, 1'b0);
    set_width(4);
    send_word(3, 1'b0);
    send_word(4, 1'b1);
    set_width(16);
    send_word(5, 1'b0);
    send_word(5, 1'b0);
    set_width(6);
    send_word(2, 1'b1);
    settle_idle();
  endtask

  task automatic test_random_phases();
    int count;
    int nw;
    bit ones;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
        1: begin in_idle_pct = 45; out_stall_pct = 0;  end
        2: begin in_idle_pct = 0;  out_stall_pct = 45; end
        default: begin in_idle_pct = 16; out_stall_pct = 16; end
      endcase
      set_width(pick_width());
      count = 0;
      while (count < PHASE_WORDS) begin
        if ($urandom_range(3) == 0) set_width(pick_width());
        ones = ($urandom_range(99) < 4);
        if (ones) nw = $urandom_range(60, 90);
        else if ($urandom_range(99) < 10) nw = $urandom_range(25, 60);
        else nw = $urandom_range(1, 20);
        send_text(nw, ones, $urandom_range(99) >= 10);
        count += nw;
      end
      settle_idle();
    end
  endtask

  task automatic test_backpressure();
    in_idle_pct = 0;
    out_stall_pct = 0;
    set_width(3);
    hold_off = 300;
    send_text(60, 1'b0, 1'b0);
    settle_idle();
    out_stall_pct = 30;
    send_text(40, 1'b0, 1'b1);
    settle_idle();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_random_phases();
    test_backpressure();
    settle_idle();
    $display("Sent %0d words over %0d width writes; checked %0d line descriptors (%0d final).",
             words_sent, width_writes, lines_checked, finals_seen);
    $display("Covered clamped, zero-length and one-char words, narrowed widths and stalls.");
    if (errors == 0 && expected_lines.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
